/* hw/rtl/min_tracking_stack_unit_defines.svh */
// Assertion macros used by the min tracking stack unit.
`ifndef MIN_TRACKING_STACK_UNIT_DEFINES_SVH
`define MIN_TRACKING_STACK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside of reset.
`define MTS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication checked at every clock edge outside of reset.
`define MTS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`else

`define MTS_ASSERT(lbl, prop, msg)
`define MTS_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

/* hw/rtl/mts_pkg.sv */
// Types and constants of the min tracking stack.
package mts_pkg;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic               op;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] top_value;
      logic signed [31:0] min_value;
      logic [6:0]         fill_count;
      logic               is_empty;
      status_type         status;
   } rsp_type;

endpackage

/* hw/rtl/mts_ram.sv */
// Generic simple dual-port RAM with registered read data.
module mts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* hw/rtl/min_tracking_stack_unit.sv */
// Push: the result appears the cycle after start, and busy stays low.
// Pop: the new top and minimum are read back from the entry RAMs, whose registered
// read data keeps busy high in S_READ; the result is registered at the end of S_READ.
// Sustained rate: one push per cycle; start is not taken while a pop holds busy high.
// Synchronous reset empties both stacks; RAM contents are not cleared.
// Results are shown for one cycle on rsp_strobe and cannot be held off.
module min_tracking_stack_unit #(
   parameter int STACK_DEPTH = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  mts_pkg::req_type req_item,
   output logic            rsp_strobe,
   output mts_pkg::rsp_type rsp_item
);

   import mts_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      vc_ff, vc_in;
   logic [CW-1:0]      mc_ff, mc_in;
   logic signed [31:0] top_ff, top_in;
   logic signed [31:0] min_ff, min_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_item_ff, rsp_item_in;
   status_type         status;

   logic               v_we, m_we;
   logic [CW-1:0]      v_rd_ptr, m_rd_ptr;
   logic [31:0]        v_rd_data, m_rd_data;

   // Pops never write, so a read always sees every earlier push.
   assign v_rd_ptr = vc_ff - CW'(2);
   assign m_rd_ptr = mc_in - CW'(1);

   mts_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_value_ram (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (vc_ff[AW-1:0]),
      .wr_data (req_item.push_value),
      .rd_addr (v_rd_ptr[AW-1:0]),
      .rd_data (v_rd_data)
   );

   mts_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_minimum_ram (
      .clock   (clock),
      .wr_en   (m_we),
      .wr_addr (mc_ff[AW-1:0]),
      .wr_data (req_item.push_value),
      .rd_addr (m_rd_ptr[AW-1:0]),
      .rd_data (m_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      vc_in         = vc_ff;
      mc_in         = mc_ff;
      top_in        = top_ff;
      min_in        = min_ff;
      rsp_strobe_in = 1'b0;
      status        = ST_OK;
      v_we          = 1'b0;
      m_we          = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_strobe_in = 1'b1;
               if (req_item.op == OP_PUSH) begin
                  if (vc_ff == CW'(STACK_DEPTH)) begin
                     status = ST_OVERFLOW;
                  end else begin
                     v_we   = 1'b1;
                     vc_in  = vc_ff + CW'(1);
                     top_in = req_item.push_value;
                     if (mc_ff == '0 || $signed(req_item.push_value) <= min_ff) begin
                        m_we   = 1'b1;
                        mc_in  = mc_ff + CW'(1);
                        min_in = req_item.push_value;
                     end
                  end
               end else begin
                  if (vc_ff == '0) begin
                     status = ST_UNDERFLOW;
                  end else begin
                     // The result waits for the new tops to come back from the RAMs.
                     rsp_strobe_in = 1'b0;
                     state_in      = S_READ;
                     vc_in         = vc_ff - CW'(1);
                     if (mc_ff != '0 && top_ff == min_ff) begin
                        mc_in = mc_ff - CW'(1);
                     end
                  end
               end
            end
         end
         S_READ: begin
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
            top_in        = $signed(v_rd_data);
            min_in        = $signed(m_rd_data);
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_item_in            = rsp_item_ff;
      if (rsp_strobe_in) begin
         rsp_item_in.top_value  = (vc_in != '0) ? top_in : EMPTY_VALUE;
         rsp_item_in.min_value  = (mc_in != '0) ? min_in : EMPTY_VALUE;
         rsp_item_in.fill_count = 7'(vc_in);
         rsp_item_in.is_empty   = (vc_in == '0);
         rsp_item_in.status     = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         vc_ff         <= '0;
         mc_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         vc_ff         <= vc_in;
         mc_ff         <= mc_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      top_ff      <= top_in;
      min_ff      <= min_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

`include "min_tracking_stack_unit_defines.svh"

   `MTS_ASSERT(a_min_count_bound, mc_ff <= vc_ff, "minimum stack deeper than value stack")
   `MTS_ASSERT(a_count_bound, vc_ff <= CW'(STACK_DEPTH), "value count beyond stack depth")
   `MTS_ASSERT_IMPL(a_min_nonempty, vc_ff != '0, mc_ff != '0, "minimum stack empty")
   `MTS_ASSERT_IMPL(a_read_done, state_ff == S_READ, ##1 rsp_strobe && !busy, "pop item lost")
   `MTS_ASSERT_IMPL(a_overflow_full, rsp_strobe && rsp_item.status == ST_OVERFLOW,
                    vc_ff == CW'(STACK_DEPTH), "overflow reported with room left")

endmodule
